>>> rtl/ofdm_ht_demap_deinterleave_top_defines.svh
// Assertion macros for the HT20 demapper and deinterleaver checks
`ifndef OFDM_HT_DEMAP_DEINTERLEAVE_TOP_DEFINES_SVH
`define OFDM_HT_DEMAP_DEINTERLEAVE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define OHDD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ofdm demap deinterleave check failed");

// Check that cons holds in the cycle after ante.
`define OHDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ofdm demap deinterleave check failed");

`endif

>>> rtl/ohdd_pkg.sv
// Shared types, constants and helper functions for the HT20 demapper and deinterleaver
package ohdd_pkg;

	localparam int SUBCARRIERS          = 52;
	localparam int COLUMNS              = 13;
	localparam int MAX_BITS_PER_CARRIER = 6;
	localparam int STORE_DEPTH          = SUBCARRIERS * MAX_BITS_PER_CARRIER;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(SUBCARRIERS + 1);
	localparam int T_W    = $clog2(MAX_BITS_PER_CARRIER);
	localparam int NB_W   = 3;
	localparam int MCS_W  = 3;
	localparam int SAMP_W = 16;

	localparam logic [NB_W-1:0] NB_BPSK  = 3'd1;
	localparam logic [NB_W-1:0] NB_QPSK  = 3'd2;
	localparam logic [NB_W-1:0] NB_QAM16 = 3'd4;
	localparam logic [NB_W-1:0] NB_QAM64 = 3'd6;

	localparam logic [SAMP_W:0] QAM16_INNER_MAX = 17'd5181;
	localparam logic [SAMP_W:0] QAM64_MID_MAX   = 17'd5056;
	localparam logic [SAMP_W:0] QAM64_BAND_MIN  = 17'd2529;
	localparam logic [SAMP_W:0] QAM64_BAND_MAX  = 17'd7584;

	typedef struct packed {
		logic signed [SAMP_W-1:0] i_sample;
		logic signed [SAMP_W-1:0] q_sample;
	} in_item_t;

	typedef struct packed {
		logic [MAX_BITS_PER_CARRIER-1:0] bit_group;
		logic [NB_W-1:0]                 group_width;
		logic                            symbol_end;
	} out_item_t;

	typedef struct packed {
		logic             accept;
		logic             issue;
		logic             rd_start;
		logic             rd_issue;
		logic             push;
		logic             last_group;
		logic [T_W-1:0]   bit_idx;
		logic [CNT_W-1:0] carrier;
	} cmd_t;

	typedef struct packed {
		logic [NB_W-1:0] nb;
		logic            pipe_busy;
		logic            out_free;
	} sts_t;

	function automatic logic [NB_W-1:0] nbpsc_of_mcs(input logic [MCS_W-1:0] mcs);
		logic [NB_W-1:0] nb;
		if (mcs == 3'd0)
			nb = NB_BPSK;
		else if (mcs inside {[3'd1:3'd2]})
			nb = NB_QPSK;
		else if (mcs inside {[3'd3:3'd4]})
			nb = NB_QAM16;
		else
			nb = NB_QAM64;
		return nb;
	endfunction

	// floor(x/3) for x below 512
	function automatic logic [ADDR_W-2:0] div3(input logic [ADDR_W-1:0] x);
		logic [18:0] p;
		p = 19'(x) * 19'd683;
		return p[18:11];
	endfunction

	// j / s with s = max(nbpsc/2, 1)
	function automatic logic [ADDR_W-1:0] div_s(input logic [ADDR_W-1:0] x,
		input logic [NB_W-1:0] nb);
		logic [ADDR_W-1:0] r;
		case (nb)
			NB_QAM16: r = x >> 1;
			NB_QAM64: r = ADDR_W'(div3(x));
			default:  r = x;
		endcase
		return r;
	endfunction

	// x * s
	function automatic logic [ADDR_W-1:0] mul_s(input logic [ADDR_W-1:0] x,
		input logic [NB_W-1:0] nb);
		logic [ADDR_W-1:0] r;
		case (nb)
			NB_QAM16: r = x << 1;
			NB_QAM64: r = x + (x << 1);
			default:  r = x;
		endcase
		return r;
	endfunction

	// x / rows with rows = 4 * nbpsc
	function automatic logic [6:0] div_rows(input logic [ADDR_W-1:0] x,
		input logic [NB_W-1:0] nb);
		logic [6:0] r;
		case (nb)
			NB_BPSK:  r = 7'(x >> 2);
			NB_QPSK:  r = 7'(x >> 3);
			NB_QAM16: r = 7'(x >> 4);
			default:  r = 7'(div3(x) >> 3);
		endcase
		return r;
	endfunction

	function automatic logic [MAX_BITS_PER_CARRIER-1:0] demap(
		input logic signed [SAMP_W-1:0] re,
		input logic signed [SAMP_W-1:0] im,
		input logic [NB_W-1:0]          nb);
		logic [SAMP_W:0]                 a;
		logic [SAMP_W:0]                 c;
		logic                            re_nn;
		logic                            im_nn;
		logic                            re_pos;
		logic                            im_pos;
		logic [MAX_BITS_PER_CARRIER-1:0] b;
		a      = re[SAMP_W-1] ? (17'd0 - {re[SAMP_W-1], re}) : {1'b0, re};
		c      = im[SAMP_W-1] ? (17'd0 - {im[SAMP_W-1], im}) : {1'b0, im};
		re_nn  = !re[SAMP_W-1];
		im_nn  = !im[SAMP_W-1];
		re_pos = re_nn && (re != 16'sd0);
		im_pos = im_nn && (im != 16'sd0);
		case (nb)
			NB_QPSK:  b = {4'b0, im_nn, re_nn};
			NB_QAM16: b = {2'b0, c <= QAM16_INNER_MAX, im_pos, a <= QAM16_INNER_MAX, re_pos};
			NB_QAM64: b = {(c >= QAM64_BAND_MIN) && (c <= QAM64_BAND_MAX), c <= QAM64_MID_MAX,
				im_pos, (a >= QAM64_BAND_MIN) && (a <= QAM64_BAND_MAX), a <= QAM64_MID_MAX,
				re_pos};
			default:  b = {5'b0, re_nn};
		endcase
		return b;
	endfunction

endpackage

>>> rtl/ofdm_ht_demap_deinterleave_top.sv
// Top level of the HT20 hard demapper and deinterleaver
//
// Input channel in_valid/in_ready/in_data carries one equalized subcarrier (I, Q in Q2.13)
// per transfer. Output channel out_valid/out_ready/out_data carries one group of nbpsc
// deinterleaved bits per transfer; symbol_end marks the 52nd group of a symbol.
// cfg_we/cfg_wdata write the MCS register; write it only while the block is idle.
// Each accepted subcarrier is written bit by bit: one bit of the decision enters the
// four-stage address pipeline (k = 13*i - (N-1)*(i/rows)) per cycle, and the single
// write port of the 312 x 1 bit store takes one bit per cycle. A new subcarrier is
// taken only once every bit of the last one has been written to the store.
// After the 52nd subcarrier the store is read group by group, one bit per cycle within
// a group; once its bits are collected, each group is loaded into the output register.
// in_ready stays low during the drain.
// A stalled receiver holds the output register and stops the drain; a new subcarrier is
// still taken while the last group of a symbol waits in the output register.
// Reset clears the MCS register to 0, the subcarrier count and all handshakes; the bit
// store is not cleared.
module ofdm_ht_demap_deinterleave_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ohdd_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ohdd_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [ohdd_pkg::MCS_W-1:0] cfg_wdata
);
	import ohdd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ohdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ohdd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> rtl/ohdd_datapath.sv
// Datapath: demap, deinterleave address pipeline, bit store and output register
module ohdd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ohdd_pkg::in_item_t           in_data,
	input  logic                         cfg_we,
	input  logic [ohdd_pkg::MCS_W-1:0]   cfg_wdata,
	input  ohdd_pkg::cmd_t               cmd,
	output ohdd_pkg::sts_t               sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output ohdd_pkg::out_item_t          out_data
);
	import ohdd_pkg::*;

	logic [MCS_W-1:0]                mcs_q;
	logic [NB_W-1:0]                 nb_q;
	logic [NB_W-1:0]                 nb_new;
	logic [MAX_BITS_PER_CARRIER-1:0] dm_q;
	logic [ADDR_W-1:0]               j_q;

	logic [ADDR_W-1:0] jdivs_a;
	logic [1:0]        jmods_a;
	logic [6:0]        jdivr_a;

	logic              v_s1;
	logic              bit_s1;
	logic [ADDR_W-1:0] jdivs_s1;
	logic [1:0]        jmods_s1;
	logic [6:0]        jdivr_s1;

	logic [7:0]        sum_b;
	logic [7:0]        sdiv_b;
	logic [1:0]        summod_b;
	logic [ADDR_W-1:0] i_b;

	logic              v_s2;
	logic              bit_s2;
	logic [ADDR_W-1:0] i_s2;

	logic              v_s3;
	logic              bit_s3;
	logic [ADDR_W-1:0] i_s3;
	logic [3:0]        q_s3;

	logic [ADDR_W-1:0] n_d;
	logic [ADDR_W-1:0] nm1_d;
	logic [12:0]       k_full_d;
	logic [ADDR_W-1:0] k_d;

	logic                            bit_store_q [STORE_DEPTH];
	logic [ADDR_W-1:0]               rd_ptr_q;
	logic                            rd_bit_q;
	logic                            rd_v_s1;
	logic [T_W-1:0]                  rd_t_s1;
	logic [MAX_BITS_PER_CARRIER-1:0] grp_q;

	logic      out_valid_q;
	out_item_t out_q;

	assign nb_new = nbpsc_of_mcs(mcs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q <= '0;
		end else if (cfg_we) begin
			mcs_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= NB_BPSK;
		end else if (cmd.accept) begin
			nb_q <= nb_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dm_q <= demap(in_data.i_sample, in_data.q_sample, nb_new);
			j_q  <= ADDR_W'(cmd.carrier) * ADDR_W'(nb_new);
		end else if (cmd.issue) begin
			j_q <= j_q + ADDR_W'(1);
		end
	end

	assign jdivs_a = div_s(j_q, nb_q);
	assign jmods_a = 2'(j_q - mul_s(jdivs_a, nb_q));
	assign jdivr_a = div_rows(j_q, nb_q);

	assign sum_b  = 8'(jmods_s1) + 8'(jdivr_s1);
	assign sdiv_b = div3(ADDR_W'(sum_b));
	always_comb begin
		case (nb_q)
			NB_QAM16: summod_b = {1'b0, sum_b[0]};
			NB_QAM64: summod_b = 2'(sum_b - (sdiv_b + (sdiv_b << 1)));
			default:  summod_b = 2'd0;
		endcase
	end
	assign i_b = mul_s(jdivs_s1, nb_q) + ADDR_W'(summod_b);

	assign n_d      = ADDR_W'(nb_q) * ADDR_W'(SUBCARRIERS);
	assign nm1_d    = n_d - ADDR_W'(1);
	assign k_full_d = 13'(COLUMNS) * 13'(i_s3) - 13'(nm1_d) * 13'(q_s3);
	assign k_d      = k_full_d[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			rd_v_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		bit_s1   <= dm_q[cmd.bit_idx];
		jdivs_s1 <= jdivs_a;
		jmods_s1 <= jmods_a;
		jdivr_s1 <= jdivr_a;
		bit_s2   <= bit_s1;
		i_s2     <= i_b;
		bit_s3   <= bit_s2;
		i_s3     <= i_s2;
		q_s3     <= 4'(div_rows(i_s2, nb_q));
		rd_t_s1  <= cmd.bit_idx;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			bit_store_q[k_d] <= bit_s3;
		end
		if (cmd.rd_issue) begin
			rd_bit_q <= bit_store_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_start) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_issue) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.push) begin
			grp_q <= '0;
		end else if (rd_v_s1) begin
			grp_q[rd_t_s1] <= rd_bit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.bit_group   <= grp_q;
			out_q.group_width <= nb_q;
			out_q.symbol_end  <= cmd.last_group;
		end
	end

	assign sts.nb        = nb_q;
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/ohdd_ctrl.sv
// Controller: sequences bit writes per subcarrier and group reads per symbol
module ohdd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output ohdd_pkg::cmd_t cmd,
	input  ohdd_pkg::sts_t sts
);
	import ohdd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WRITE = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_READ  = 6'b001000,
		ST_LAST  = 6'b010000,
		ST_PUSH  = 6'b100000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [T_W-1:0]   t_q;
	logic [T_W-1:0]   t_d;
	logic [CNT_W-1:0] carrier_q;
	logic [CNT_W-1:0] carrier_d;
	logic [CNT_W-1:0] grp_idx_q;
	logic [CNT_W-1:0] grp_idx_d;
	logic             t_last;

	assign t_last = (t_q == T_W'(sts.nb - NB_W'(1)));

	always_comb begin
		state_d        = state_q;
		t_d            = t_q;
		carrier_d      = carrier_q;
		grp_idx_d      = grp_idx_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.bit_idx    = t_q;
		cmd.carrier    = carrier_q;
		cmd.last_group = (grp_idx_q == CNT_W'(SUBCARRIERS - 1));
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					t_d        = '0;
					state_d    = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.issue = 1'b1;
				if (t_last) begin
					t_d       = '0;
					carrier_d = carrier_q + CNT_W'(1);
					state_d   = ST_DRAIN;
				end else begin
					t_d = t_q + T_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					if (carrier_q == CNT_W'(SUBCARRIERS)) begin
						carrier_d    = '0;
						grp_idx_d    = '0;
						cmd.rd_start = 1'b1;
						state_d      = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				if (t_last) begin
					t_d     = '0;
					state_d = ST_LAST;
				end else begin
					t_d = t_q + T_W'(1);
				end
			end
			ST_LAST: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					if (cmd.last_group) begin
						state_d = ST_IDLE;
					end else begin
						grp_idx_d = grp_idx_q + CNT_W'(1);
						state_d   = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			t_q       <= '0;
			carrier_q <= '0;
			grp_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			t_q       <= t_d;
			carrier_q <= carrier_d;
			grp_idx_q <= grp_idx_d;
		end
	end

endmodule

>>> rtl/ohdd_checker.sv
// Port-level checks for the HT20 demapper and deinterleaver, bound to the top level
`include "ofdm_ht_demap_deinterleave_top_defines.svh"

module ohdd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ohdd_pkg::out_item_t out_data
);

	`OHDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	`OHDD_ASSERT_NOW(a_width_legal, out_valid, out_data.group_width == 3'd1 || out_data.group_width == 3'd2 || out_data.group_width == 3'd4 || out_data.group_width == 3'd6)

	`OHDD_ASSERT_NOW(a_upper_zero, out_valid, (out_data.bit_group >> out_data.group_width) == 6'd0)

	`OHDD_ASSERT_NOW(a_no_take_mid_symbol, out_valid && !out_data.symbol_end, !in_ready)

endmodule

bind ofdm_ht_demap_deinterleave_top ohdd_checker u_ohdd_checker (.*);

>>> tb/ofdm_ht_demap_deinterleave_top_tb.sv
// Self-checking testbench for the HT20 hard demapper and deinterleaver
`timescale 1ns / 100ps

module ofdm_ht_demap_deinterleave_top_tb;
	import ohdd_pkg::*;

	localparam int N_CARRIERS    = 52;
	localparam int N_COLS        = 13;
	localparam int N_STORE       = 312;
	localparam int INNER16_LIMIT = 5181;
	localparam int MID64_LIMIT   = 5056;
	localparam int BAND64_LO     = 2529;
	localparam int BAND64_HI     = 7584;
	localparam int RANDOM_ITEMS  = 460;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_GAP       = 11;
	localparam int LOG_LIMIT     = 10;
	localparam int N_PROBES      = 24;
	localparam int N_CORNERS     = 21;
	localparam logic [MCS_W-1:0] MCS_LOWEST  = 3'd0;
	localparam logic [MCS_W-1:0] MCS_HIGHEST = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [MCS_W-1:0]      cfg_wdata = '0;

	// 64-QAM threshold probes, sent right after reset
	int probe_i[N_PROBES] = '{0, 1, -1, 32767, -32768, 5056, 5057, -5057, 2528, 2529, -2529,
		7584, 7585, -7585, 5181, -5182, 8192, 2000, -3000, 6000, 100, -1, 0, 16384};
	int probe_q[N_PROBES] = '{0, -1, 1, -32768, 32767, -5056, -5057, 5057, -2528, 2529, -2528,
		-7584, -7585, 7585, 5182, -5181, -8192, -6000, 4000, -1000, -100, 0, -1, -16384};
	int corner_vals[N_CORNERS] = '{0, 1, -1, 32767, -32768, 5181, 5182, -5181, -5182, 5056,
		5057, -5056, -5057, 2528, 2529, -2528, -2529, 7584, 7585, -7584, -7585};

	logic             store_bits[N_STORE];
	int               carrier_idx;
	logic [MCS_W-1:0] mcs_now;
	out_item_t        pending_groups[$];
	int               idle_burst[2];
	int               errors;
	int               carriers_sent;
	int               groups_seen;
	int               symbols_done;
	int               mcs_writes;
	int               mid_switches;

	ofdm_ht_demap_deinterleave_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("ofdm_ht_demap_deinterleave_top_tb NOT OK");
		$finish;
	end

	function automatic int bits_for(input logic [MCS_W-1:0] m);
		case (m)
			3'd0:       return 1;
			3'd1, 3'd2: return 2;
			3'd3, 3'd4: return 4;
			default:    return 6;
		endcase
	endfunction

	function automatic logic [5:0] decide(input int re, input int im, input int nb);
		int         a;
		int         c;
		logic [5:0] b;
		a = re < 0 ? -re : re;
		c = im < 0 ? -im : im;
		b = '0;
		case (nb)
			1: begin
				b[0] = re >= 0;
			end
			2: begin
				b[0] = re >= 0;
				b[1] = im >= 0;
			end
			4: begin
				b[0] = re > 0;
				b[1] = a <= INNER16_LIMIT;
				b[2] = im > 0;
				b[3] = c <= INNER16_LIMIT;
			end
			default: begin
				b[0] = re > 0;
				b[1] = a <= MID64_LIMIT;
				b[2] = a >= BAND64_LO && a <= BAND64_HI;
				b[3] = im > 0;
				b[4] = c <= MID64_LIMIT;
				b[5] = c >= BAND64_LO && c <= BAND64_HI;
			end
		endcase
		return b;
	endfunction

	function automatic int deint_index(input int j, input int nb);
		int n;
		int s;
		int rows;
		int i;
		n    = N_CARRIERS * nb;
		s    = nb / 2;
		rows = n / N_COLS;
		if (s == 0) begin
			s = 1;
		end
		i = s * (j / s) + ((j + (N_COLS * j) / n) % s);
		return N_COLS * i - (n - 1) * (i / rows);
	endfunction

	// place one carrier's decisions; after the last carrier queue the whole symbol
	function automatic void place_carrier(input in_item_t it);
		int         nb;
		int         t;
		int         g;
		logic [5:0] b;
		out_item_t  grp;
		nb = bits_for(mcs_now);
		b  = decide(int'(it.i_sample), int'(it.q_sample), nb);
		for (t = 0; t < nb; t++) begin
			store_bits[deint_index(carrier_idx * nb + t, nb)] = b[t];
		end
		carrier_idx++;
		if (carrier_idx < N_CARRIERS) begin
			return;
		end
		carrier_idx = 0;
		symbols_done++;
		for (g = 0; g < N_CARRIERS; g++) begin
			grp = '0;
			for (t = 0; t < nb; t++) begin
				grp.bit_group[t] = store_bits[g * nb + t];
			end
			grp.group_width = 3'(nb);
			grp.symbol_end  = (g == N_CARRIERS - 1);
			pending_groups.insert(pending_groups.size(), grp);
		end
	endfunction

	function automatic int draw_gap(input int side);
		if (idle_burst[side] > 0) begin
			idle_burst[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			idle_burst[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic signed [SAMP_W-1:0] draw_level();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = corner_vals[$urandom_range(0, N_CORNERS - 1)];
			default: v = $urandom_range(0, 18000) - 9000;
		endcase
		return SAMP_W'(v);
	endfunction

	task automatic push_carrier(input in_item_t it);
		int gap;
		gap = draw_gap(0);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		place_carrier(it);
		carriers_sent++;
	endtask

	// drop valid, wait for every queued group, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_groups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mcs(input logic [MCS_W-1:0] m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		mcs_now = m;
		mcs_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: hold ready low for a random stall, then high until a transfer
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = draw_gap(1);
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				groups_seen++;
				if (pending_groups.size() == 0) begin
					errors++;
					if (errors <= LOG_LIMIT) begin
						$display("unexpected group grp=%02h w=%0d end=%0b",
							out_data.bit_group, out_data.group_width, out_data.symbol_end);
					end
				end else begin
					want = pending_groups.pop_front();
					if (out_data !== want) begin
						errors++;
						if (errors <= LOG_LIMIT) begin
							$display("group %0d: expected grp=%02h w=%0d end=%0b, got grp=%02h w=%0d end=%0b",
								groups_seen, want.bit_group, want.group_width, want.symbol_end,
								out_data.bit_group, out_data.group_width, out_data.symbol_end);
						end
					end
				end
			end
		end
	end

	initial begin
		in_item_t         it;
		int               n;
		logic [MCS_W-1:0] next_mcs;
		carrier_idx   = 0;
		mcs_now       = MCS_LOWEST;
		idle_burst    = '{0, 0};
		errors        = 0;
		carriers_sent = 0;
		groups_seen   = 0;
		symbols_done  = 0;
		mcs_writes    = 0;
		mid_switches  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first symbol runs entirely at 64-QAM so every store entry gets written
		write_mcs(MCS_HIGHEST);
		for (n = 0; n < N_PROBES; n++) begin
			it.i_sample = SAMP_W'(probe_i[n]);
			it.q_sample = SAMP_W'(probe_q[n]);
			push_carrier(it);
		end

		while (carriers_sent < RANDOM_ITEMS || carrier_idx != 0) begin
			if (carrier_idx == 0) begin
				next_mcs = (symbols_done <= 8) ? MCS_W'(symbols_done - 1)
					: MCS_W'($urandom_range(0, 7));
				settle();
				write_mcs(next_mcs);
			end else if (symbols_done > 0 && $urandom_range(0, 47) == 0) begin
				settle();
				write_mcs(MCS_W'($urandom_range(0, 7)));
				mid_switches++;
			end
			it.i_sample = draw_level();
			it.q_sample = draw_level();
			push_carrier(it);
		end

		settle();
		errors += pending_groups.size();
		$display("sent %0d subcarriers in %0d symbols, checked %0d bit groups",
			carriers_sent, symbols_done, groups_seen);
		$display("%0d MCS writes, %0d of them inside a symbol, %0d mismatches",
			mcs_writes, mid_switches, errors);
		if (errors == 0) begin
			$display("ofdm_ht_demap_deinterleave_top_tb OK");
		end else begin
			$display("ofdm_ht_demap_deinterleave_top_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/ohdd_pkg.sv
rtl/ohdd_datapath.sv
rtl/ohdd_ctrl.sv
rtl/ofdm_ht_demap_deinterleave_top.sv
rtl/ohdd_checker.sv
tb/ofdm_ht_demap_deinterleave_top_tb.sv
